// File: rtl/core/mieu_pkg.sv
// Package for the MIPS64 integer execute unit: operation codes, widths,
// state type and mul/div command/status structs. No dependencies.
package mieu_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned HalfW = 32;
  localparam int unsigned CntW  = 7;

  typedef enum logic [5:0] {
    OP_ADD = 6'd0, OP_ADDI = 6'd1, OP_ADDIU = 6'd2, OP_ADDU = 6'd3, OP_AND = 6'd4,
    OP_ANDI = 6'd5, OP_DADD = 6'd6, OP_DADDI = 6'd7, OP_DADDIU = 6'd8, OP_DADDU = 6'd9,
    OP_DDIV = 6'd10, OP_DDIVU = 6'd11, OP_DIV = 6'd12, OP_DIVU = 6'd13, OP_DMULT = 6'd14,
    OP_DMULTU = 6'd15, OP_DSLL = 6'd16, OP_DSLL32 = 6'd17, OP_DSLLV = 6'd18,
    OP_DSRA = 6'd19, OP_DSRA32 = 6'd20, OP_DSRAV = 6'd21, OP_DSRL = 6'd22,
    OP_DSRL32 = 6'd23, OP_DSRLV = 6'd24, OP_DSUB = 6'd25, OP_DSUBU = 6'd26,
    OP_LUI = 6'd27, OP_MFHI = 6'd28, OP_MFLO = 6'd29, OP_MTHI = 6'd30, OP_MTLO = 6'd31,
    OP_MULT = 6'd32, OP_MULTU = 6'd33, OP_NOR = 6'd34, OP_OR = 6'd35, OP_ORI = 6'd36,
    OP_SLL = 6'd37, OP_SLLV = 6'd38, OP_SLT = 6'd39, OP_SLTI = 6'd40, OP_SLTIU = 6'd41,
    OP_SLTU = 6'd42, OP_SRA = 6'd43, OP_SRAV = 6'd44, OP_SRL = 6'd45, OP_SRLV = 6'd46,
    OP_SUB = 6'd47, OP_SUBU = 6'd48, OP_XOR = 6'd49, OP_XORI = 6'd50
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ALU, ST_MUL, ST_DIV, ST_FIX, ST_DONE
  } state_t;

  // mul/div unit control
  typedef struct packed {
    logic       start;
    logic       is_div;
    logic       is_signed;
    logic       is_word;
  } md_cmd_t;

  typedef struct packed {
    logic       done;
    logic       write;
  } md_sts_t;

endpackage

// File: rtl/core/mieu_muldiv.sv
// Bit-serial shift-add multiplier and restoring divider for HI/LO.
// Depends on mieu_pkg.
module mieu_muldiv import mieu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  md_cmd_t          cmd,
  input  logic [DataW-1:0] a_in,
  input  logic [DataW-1:0] b_in,
  output md_sts_t          sts,
  output logic [DataW-1:0] hi_res,
  output logic [DataW-1:0] lo_res
);

  logic             busy;
  logic             fix;
  logic [CntW-1:0]  cnt;
  logic             is_div, neg_q, neg_r, word;
  logic [DataW-1:0] acc;   // product high / remainder
  logic [DataW-1:0] sh;    // multiplier low / quotient
  logic [DataW-1:0] bb;
  logic [DataW:0]   sum;
  logic [DataW:0]   diff;
  logic [DataW-1:0] a_op, b_op, a_mag, b_mag;
  logic             zero_div;
  logic [DataW-1:0] q_f, r_f, p_hi, p_lo;

  always_comb begin
    a_op = a_in;
    b_op = b_in;
    if (cmd.is_word) begin
      a_op = cmd.is_signed ? {{HalfW{a_in[HalfW-1]}}, a_in[HalfW-1:0]}
                           : {{HalfW{1'b0}}, a_in[HalfW-1:0]};
      b_op = cmd.is_signed ? {{HalfW{b_in[HalfW-1]}}, b_in[HalfW-1:0]}
                           : {{HalfW{1'b0}}, b_in[HalfW-1:0]};
    end
    a_mag = (cmd.is_signed && a_op[DataW-1]) ? DataW'(0) - a_op : a_op;
    b_mag = (cmd.is_signed && b_op[DataW-1]) ? DataW'(0) - b_op : b_op;
    zero_div = (b_op == '0);
    sum  = {1'b0, acc} + (sh[0] ? {1'b0, bb} : {(DataW+1){1'b0}});
    diff = {acc[DataW-2:0], sh[DataW-1]} - {1'b0, bb};
    q_f  = neg_q ? DataW'(0) - sh : sh;
    r_f  = neg_r ? DataW'(0) - acc : acc;
    p_lo = sh;
    p_hi = acc;
    if (neg_q) begin
      p_lo = ~sh + DataW'(1);
      p_hi = ~acc + DataW'(sh == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      sts  <= '0;
      cnt  <= '0;
    end else begin
      if (cmd.start) begin
        is_div <= cmd.is_div;
        word   <= cmd.is_word;
        neg_q  <= cmd.is_signed && (a_op[DataW-1] ^ b_op[DataW-1]);
        neg_r  <= cmd.is_signed && a_op[DataW-1];
        acc    <= '0;
        sh     <= a_mag;
        bb     <= b_mag;
        cnt    <= '0;
        sts    <= '{done: cmd.is_div && zero_div, write: 1'b0};
        if (!(cmd.is_div && zero_div)) busy <= 1'b1;
      end else if (busy) begin
        sts <= '0;
        if (is_div) begin
          if (!diff[DataW]) begin
            acc <= diff[DataW-1:0];
            sh  <= {sh[DataW-2:0], 1'b1};
          end else begin
            acc <= {acc[DataW-2:0], sh[DataW-1]};
            sh  <= {sh[DataW-2:0], 1'b0};
          end
        end else begin
          {acc, sh} <= {sum, sh[DataW-1:1]};
        end
        cnt <= cnt + CntW'(1);
        if (cnt == CntW'(DataW-1)) begin
          busy <= 1'b0;
          fix  <= 1'b1;
        end
      end else if (fix) begin
        fix <= 1'b0;
        sts <= '{done: 1'b1, write: 1'b1};
        if (is_div) begin
          hi_res <= word ? {{HalfW{r_f[HalfW-1]}}, r_f[HalfW-1:0]} : r_f;
          lo_res <= word ? {{HalfW{q_f[HalfW-1]}}, q_f[HalfW-1:0]} : q_f;
        end else if (word) begin
          hi_res <= {{HalfW{p_lo[DataW-1]}}, p_lo[DataW-1:HalfW]};
          lo_res <= {{HalfW{p_lo[HalfW-1]}}, p_lo[HalfW-1:0]};
        end else begin
          hi_res <= p_hi;
          lo_res <= p_lo;
        end
      end else begin
        sts <= '0;
      end
    end
  end

endmodule

// File: rtl/core/mieu_alu.sv
// ALU for the operations other than multiply and divide, registered output.
// Depends on mieu_pkg.
module mieu_alu import mieu_pkg::*; (
  input  logic             clk,
  input  op_t              op,
  input  logic [DataW-1:0] rs,
  input  logic [DataW-1:0] rt,
  input  logic [15:0]      imm,
  input  logic [4:0]       sa,
  input  logic [DataW-1:0] hi,
  input  logic [DataW-1:0] lo,
  output logic [DataW-1:0] res,
  output logic             wr,
  output logic             to_rt
);

  logic [DataW-1:0] simm, zimm, sum, dif, r, rt32s, rt32z;
  logic [5:0]       s64;
  logic [4:0]       s32;
  logic             w, t;

  function automatic logic [DataW-1:0] sx(input logic [DataW-1:0] x);
    sx = {{HalfW{x[HalfW-1]}}, x[HalfW-1:0]};
  endfunction

  always_comb begin
    simm  = {{48{imm[15]}}, imm};
    zimm  = {48'd0, imm};
    sum   = rs + ((op == OP_ADD || op == OP_ADDU || op == OP_DADD || op == OP_DADDU)
                  ? rt : simm);
    dif   = rs - rt;
    rt32s = sx(rt);
    rt32z = {{HalfW{1'b0}}, rt[HalfW-1:0]};
    s64   = rs[5:0];
    s32   = rs[4:0];
    r = '0;
    w = 1'b1;
    t = 1'b0;
    unique case (op)
      OP_ADD, OP_ADDU: r = sx(sum);
      OP_ADDI, OP_ADDIU: begin r = sx(sum); t = 1'b1; end
      OP_AND: r = rs & rt;
      OP_ANDI: begin r = rs & zimm; t = 1'b1; end
      OP_DADD, OP_DADDU: r = sum;
      OP_DADDI, OP_DADDIU: begin r = sum; t = 1'b1; end
      OP_DSLL: r = rt << sa;
      OP_DSLL32: r = rt << {1'b1, sa};
      OP_DSLLV: r = rt << s64;
      OP_DSRA: r = DataW'($signed(rt) >>> sa);
      OP_DSRA32: r = DataW'($signed(rt) >>> {1'b1, sa});
      OP_DSRAV: r = DataW'($signed(rt) >>> s64);
      OP_DSRL: r = rt >> sa;
      OP_DSRL32: r = rt >> {1'b1, sa};
      OP_DSRLV: r = rt >> s64;
      OP_DSUB, OP_DSUBU: r = dif;
      OP_LUI: begin r = sx({32'd0, imm, 16'd0}); t = 1'b1; end
      OP_MFHI: r = hi;
      OP_MFLO: r = lo;
      OP_NOR: r = ~(rs | rt);
      OP_OR: r = rs | rt;
      OP_ORI: begin r = rs | zimm; t = 1'b1; end
      OP_SLL: r = sx(rt << sa);
      OP_SLLV: r = sx(rt << s32);
      OP_SLT: r = DataW'($signed(rs) < $signed(rt));
      OP_SLTI: begin r = DataW'($signed(rs) < $signed(simm)); t = 1'b1; end
      OP_SLTIU: begin r = DataW'(rs < zimm); t = 1'b1; end
      OP_SLTU: r = DataW'(rs < rt);
      OP_SRA: r = DataW'($signed(rt32s) >>> sa);
      OP_SRAV: r = DataW'($signed(rt32s) >>> s32);
      OP_SRL: r = sx(rt32z >> sa);
      OP_SRLV: r = sx(rt32z >> s32);
      OP_SUB, OP_SUBU: r = sx(dif);
      OP_XOR: r = rs ^ rt;
      OP_XORI: begin r = rs ^ zimm; t = 1'b1; end
      default: w = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    res   <= w ? r : '0;
    wr    <= w;
    to_rt <= w & t;
  end

endmodule

// File: rtl/core/mips64_integer_execute_unit.sv
// Channel   | signals                                          | handshake
// command   | action rs_value rt_value immediate shift_amount | start & !busy
// result    | result writes_register dest_is_rt               | done (1 cycle)
// ALU, MFHI/MFLO items: done in ST_ALU with the registered ALU result.
// MTHI/MTLO: same path. Divide by zero: done from mul/div status in ST_MUL.
// Multiplies and divides: done after the bit-serial steps and the fix-up.
// rst clears HI, LO and control. busy is high from acceptance to done.
// Depends on mieu_pkg, mieu_alu, mieu_muldiv.
module mips64_integer_execute_unit import mieu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [5:0]       action,
  input  logic [63:0]      rs_value,
  input  logic [63:0]      rt_value,
  input  logic [15:0]      immediate,
  input  logic [4:0]       shift_amount,
  output logic             done,
  output logic [63:0]      result,
  output logic             writes_register,
  output logic             dest_is_rt
);

  state_t           state, state_next;
  logic [DataW-1:0] hi, lo, md_hi, md_lo;
  logic [DataW-1:0] alu_res;
  logic             alu_wr, alu_rt;
  md_cmd_t          md_cmd;
  md_sts_t          md_sts;
  op_t              op;
  logic             is_md;

  assign op = op_t'(action);

  always_comb begin
    md_cmd = '0;
    is_md  = 1'b1;
    unique case (op)
      OP_DDIV:   md_cmd = '{start: 1'b1, is_div: 1'b1, is_signed: 1'b1, is_word: 1'b0};
      OP_DDIVU:  md_cmd = '{start: 1'b1, is_div: 1'b1, is_signed: 1'b0, is_word: 1'b0};
      OP_DIV:    md_cmd = '{start: 1'b1, is_div: 1'b1, is_signed: 1'b1, is_word: 1'b1};
      OP_DIVU:   md_cmd = '{start: 1'b1, is_div: 1'b1, is_signed: 1'b0, is_word: 1'b1};
      OP_DMULT:  md_cmd = '{start: 1'b1, is_div: 1'b0, is_signed: 1'b1, is_word: 1'b0};
      OP_DMULTU: md_cmd = '{start: 1'b1, is_div: 1'b0, is_signed: 1'b0, is_word: 1'b0};
      OP_MULT:   md_cmd = '{start: 1'b1, is_div: 1'b0, is_signed: 1'b1, is_word: 1'b1};
      OP_MULTU:  md_cmd = '{start: 1'b1, is_div: 1'b0, is_signed: 1'b0, is_word: 1'b1};
      default:   is_md = 1'b0;
    endcase
    md_cmd.start = md_cmd.start && start && state == ST_IDLE;
  end

  mieu_alu u_alu (
    .clk(clk), .op(op), .rs(rs_value), .rt(rt_value), .imm(immediate),
    .sa(shift_amount), .hi(hi), .lo(lo), .res(alu_res), .wr(alu_wr), .to_rt(alu_rt)
  );

  mieu_muldiv u_md (
    .clk(clk), .rst(rst), .cmd(md_cmd), .a_in(rs_value), .b_in(rt_value),
    .sts(md_sts), .hi_res(md_hi), .lo_res(md_lo)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = is_md ? ST_MUL : ST_ALU;
      ST_ALU:  state_next = ST_IDLE;
      ST_MUL:  if (md_sts.done) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hi    <= '0;
      lo    <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && start && op == OP_MTHI) hi <= rs_value;
      if (state == ST_IDLE && start && op == OP_MTLO) lo <= rs_value;
      if (state == ST_MUL && md_sts.done && md_sts.write) begin
        hi <= md_hi;
        lo <= md_lo;
      end
    end
  end

  assign busy            = (state != ST_IDLE);
  assign done            = (state == ST_ALU) || (state == ST_MUL && md_sts.done);
  assign result          = (state == ST_ALU) ? alu_res : '0;
  assign writes_register = (state == ST_ALU) && alu_wr;
  assign dest_is_rt      = (state == ST_ALU) && alu_rt;

endmodule

// File: rtl/core/mieu_checker.sv
// Port-level checker for the MIPS64 integer execute unit, with its bind.
// Depends on mips64_integer_execute_unit ports only.
module mieu_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [63:0] result,
  input logic        writes_register,
  input logic        dest_is_rt
);

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accept did not raise busy");
  a_nowr_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !writes_register) |-> (result == 64'd0 && !dest_is_rt))
    else $error("non-writing item has payload");
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    (busy && !done) |=> busy) else $error("busy dropped without done");

endmodule

bind mips64_integer_execute_unit mieu_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result),
  .writes_register(writes_register), .dest_is_rt(dest_is_rt)
);
